[sv/bitmap_page_allocator_top_assert.svh]
// assertion macros for the bitmap page allocator
// expects signals clk and rst_n in the module that uses them
`ifndef BITMAP_PAGE_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define BPA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define BPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/bpa_pkg.sv]
// shared types and codes for the bitmap page allocator
// no dependencies
package bpa_pkg;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_NORUN = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  // free run seen from the current bit offset of one bitmap word
  typedef struct packed {
    logic [5:0] zeros;
    logic       hit_end;
  } scan_res_t;

endpackage

[sv/bitmap_page_allocator_top.sv]
// free: read the word, clear the bit, reply; allocate: scan words, crossing used runs, then mark the run's words
// one transaction at a time, scan walks the bitmap ram one 32-page word at a time
// reset and any total_pages write start a clearing pass over all bitmap words, no input taken
// file: top level of the bitmap page allocator, uses bpa_pkg and bpa_scan
// assertions come from bitmap_page_allocator_top_assert.svh
module bitmap_page_allocator_top import bpa_pkg::*; #(
  parameter int NUM_PAGES  = 4096,
  parameter int PAGE_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [23:0] in_addr,
  input  logic [24:0] in_size_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [23:0] out_result_addr,
  output logic [12:0] out_free_pages_now,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_total_pages
);

`include "bitmap_page_allocator_top_assert.svh"

  localparam int OFF_W  = $clog2(PAGE_BYTES);
  localparam int SPW    = 24 - OFF_W;
  localparam int WORDS  = (NUM_PAGES + 31) / 32;
  localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CNT_W  = $clog2(NUM_PAGES + 1);
  localparam int NEED_W = 26 - OFF_W;
  localparam int M1 = (WA_W + 6 > SPW + 1) ? WA_W + 6 : SPW + 1;
  localparam int M2 = (M1 > NEED_W) ? M1 : NEED_W;
  localparam int M3 = (M2 > CNT_W) ? M2 : CNT_W;
  localparam int CW = ((M3 > 14) ? M3 : 14) + 1;

  typedef enum logic [5:0] {
    ST_CLR  = 6'b000001,
    ST_IDLE = 6'b000010,
    ST_SCAN = 6'b000100,
    ST_MARK = 6'b001000,
    ST_FREE = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  logic [31:0] mem [WORDS];
  logic [31:0] rdata_r;

  state_t      state_r, state_nxt;
  logic [12:0] total_r;
  logic [CNT_W-1:0] free_r, free_nxt;
  logic [WA_W-1:0]  clr_r, clr_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] run_len_r, run_len_nxt;
  logic [CW-1:0] run_start_r, run_start_nxt;
  logic [CW-1:0] need_r, need_nxt;
  logic [CW-1:0] mpos_r, mpos_nxt;
  logic [CW-1:0] mleft_r, mleft_nxt;
  logic [1:0]  res_stat_r, res_stat_nxt;
  logic [23:0] res_addr_r, res_addr_nxt;
  logic        out_valid_r;
  logic [1:0]  out_stat_r;
  logic [23:0] out_addr_r;
  logic [12:0] out_free_r;

  logic [CW-1:0] lim, sp_c, wbase, start_c, total_c, npos, need_c;
  logic [25:0]   size_up;
  logic [31:0]   free_v, lenmask;
  logic [5:0]    room;
  scan_res_t     sres;
  logic          rd_en, wr_en, out_load;
  logic [WA_W-1:0] rd_addr, wr_addr;
  logic [31:0]   wr_data;

  assign lim = (CW'(total_r) > CW'(NUM_PAGES)) ? CW'(NUM_PAGES) : CW'(total_r);
  assign sp_c = CW'(in_addr >> OFF_W);
  assign size_up = {1'b0, in_size_bytes} + 26'(PAGE_BYTES - 1);
  assign need_c = (in_size_bytes == '0) ? CW'(1) : CW'(size_up >> OFF_W);

  assign wbase = {pos_r[CW-1:5], 5'd0};
  always_comb begin
    for (int i = 0; i < 32; i++) begin
      free_v[i] = !rdata_r[i] && ((wbase + CW'(i)) < lim);
    end
  end

  bpa_scan u_scan (
    .free_v (free_v),
    .off    (pos_r[4:0]),
    .res    (sres)
  );

  assign start_c = (run_len_r == '0) ? pos_r : run_start_r;
  assign total_c = run_len_r + CW'(sres.zeros);

  assign room    = 6'd32 - {1'b0, mpos_r[4:0]};
  assign lenmask = (mleft_r >= CW'(32)) ? '1 : ((32'h1 << mleft_r[4:0]) - 32'h1);

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    free_nxt      = free_r;
    clr_nxt       = clr_r;
    pos_nxt       = pos_r;
    run_len_nxt   = run_len_r;
    run_start_nxt = run_start_r;
    need_nxt      = need_r;
    mpos_nxt      = mpos_r;
    mleft_nxt     = mleft_r;
    res_stat_nxt  = res_stat_r;
    res_addr_nxt  = res_addr_r;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = clr_r;
    wr_data = '0;
    npos    = '0;
    case (state_r)
      ST_CLR: begin
        wr_en = 1'b1;
        clr_nxt = clr_r + WA_W'(1);
        if (clr_r == WA_W'(WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          res_addr_nxt = '0;
          res_stat_nxt = STAT_DONE;
          if (sp_c >= lim) begin
            res_stat_nxt = (in_cmd == CMD_FREE) ? STAT_RANGE : STAT_NORUN;
            state_nxt = ST_OUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = sp_c[WA_W+4:5];
            if (in_cmd == CMD_FREE) begin
              mpos_nxt  = sp_c;
              state_nxt = ST_FREE;
            end else begin
              pos_nxt     = sp_c;
              run_len_nxt = '0;
              need_nxt    = need_c;
              state_nxt   = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (total_c >= need_r) begin
          mpos_nxt     = start_c;
          mleft_nxt    = need_r;
          free_nxt     = (CW'(free_r) < need_r) ? '0 : free_r - CNT_W'(need_r);
          res_addr_nxt = 24'(start_c) << OFF_W;
          rd_en        = 1'b1;
          rd_addr      = start_c[WA_W+4:5];
          state_nxt    = ST_MARK;
        end else begin
          if (sres.hit_end) begin
            run_len_nxt   = total_c;
            run_start_nxt = start_c;
            npos          = wbase + CW'(32);
          end else begin
            run_len_nxt = '0;
            npos        = pos_r + CW'(sres.zeros) + CW'(1);
          end
          if (npos >= lim) begin
            res_stat_nxt = STAT_NORUN;
            state_nxt    = ST_OUT;
          end else begin
            pos_nxt = npos;
            rd_en   = (npos[4:0] == 5'd0);
            rd_addr = npos[WA_W+4:5];
          end
        end
      end
      ST_MARK: begin
        wr_en   = 1'b1;
        wr_addr = mpos_r[WA_W+4:5];
        wr_data = rdata_r | (lenmask << mpos_r[4:0]);
        if (mleft_r <= CW'(room)) begin
          state_nxt = ST_OUT;
        end else begin
          mleft_nxt = mleft_r - CW'(room);
          mpos_nxt  = {mpos_r[CW-1:5] + (CW-5)'(1), 5'd0};
          rd_en     = 1'b1;
          rd_addr   = mpos_nxt[WA_W+4:5];
        end
      end
      ST_FREE: begin
        wr_en   = 1'b1;
        wr_addr = mpos_r[WA_W+4:5];
        wr_data = rdata_r & ~(32'h1 << mpos_r[4:0]);
        if (CW'(free_r) < lim) begin
          free_nxt = free_r + CNT_W'(1);
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      total_r     <= 13'd4096;
      free_r      <= (NUM_PAGES < 4096) ? CNT_W'(NUM_PAGES) : CNT_W'(4096);
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        // new page count: reload and sweep the bitmap again
        total_r <= cfg_total_pages;
        free_r  <= (CW'(cfg_total_pages) > CW'(NUM_PAGES)) ? CNT_W'(NUM_PAGES)
                                                          : CNT_W'(cfg_total_pages);
        clr_r   <= '0;
        state_r <= ST_CLR;
      end else begin
        state_r <= state_nxt;
        free_r  <= free_nxt;
        clr_r   <= clr_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    run_len_r   <= run_len_nxt;
    run_start_r <= run_start_nxt;
    need_r      <= need_nxt;
    mpos_r      <= mpos_nxt;
    mleft_r     <= mleft_nxt;
    res_stat_r  <= res_stat_nxt;
    res_addr_r  <= res_addr_nxt;
    if (out_load) begin
      out_stat_r <= res_stat_r;
      out_addr_r <= res_addr_r;
      out_free_r <= 13'(free_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_stat_r;
  assign out_result_addr    = out_addr_r;
  assign out_free_pages_now = out_free_r;

  `BPA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `BPA_ASSERT_NOW(a_free_within_limit, 1'b1, CW'(free_r) <= lim)
  `BPA_ASSERT_NEXT(a_cfg_starts_clear, cfg_valid && cfg_ready, state_r == ST_CLR)
  `BPA_ASSERT_NOW(a_scan_in_range, state_r == ST_SCAN, pos_r < lim)

endmodule

[sv/bpa_scan.sv]
// free-run counter for one 32-bit bitmap word
// depends on bpa_pkg
module bpa_scan import bpa_pkg::*; (
  input  logic [31:0] free_v,
  input  logic [4:0]  off,
  output scan_res_t   res
);

  logic [31:0] stop;
  logic [5:0]  z;

  // bits shifted in from the top read as not free
  assign stop = ~(free_v >> off);

  always_comb begin
    z = 6'd32;
    for (int i = 31; i >= 0; i--) begin
      if (stop[i]) begin
        z = 6'(i);
      end
    end
  end

  assign res.zeros   = z;
  assign res.hit_end = ((z + {1'b0, off}) == 6'd32);

endmodule

[tb/bitmap_page_allocator_checker.sv]
`timescale 1ns / 100ps
// scoreboard for the bitmap page allocator: watches the three channels, predicts and compares
// depends on bpa_pkg for the command and status codes
module bitmap_page_allocator_checker import bpa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_cmd,
  input  logic [23:0] in_addr,
  input  logic [24:0] in_size_bytes,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [23:0] out_result_addr,
  input  logic [12:0] out_free_pages_now,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [12:0] cfg_total_pages,
  output int unsigned n_fail,
  output int unsigned n_pending
);

  localparam int NUM_PAGES  = 4096;
  localparam int PAGE_BYTES = 4096;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] addr;
    logic [12:0] free_now;
  } alloc_reply_t;

  logic        page_used [NUM_PAGES];
  int unsigned free_cnt;
  int unsigned reg_pages;
  alloc_reply_t reply_q[$];

  function automatic int unsigned managed();
    return (reg_pages < NUM_PAGES) ? reg_pages : NUM_PAGES;
  endfunction

  function automatic void clear_map();
    foreach (page_used[i]) page_used[i] = 1'b0;
    free_cnt = managed();
  endfunction

  function automatic alloc_reply_t compute_reply(logic cmd, logic [23:0] addr,
                                                 logic [24:0] size);
    alloc_reply_t r;
    int unsigned lim, pg, need, run_start, run_len;
    longint unsigned base;
    lim = managed();
    pg = addr / PAGE_BYTES;
    r = '0;
    if (cmd == CMD_FREE) begin
      if (pg >= lim) begin
        r.status = STAT_RANGE;
      end else begin
        page_used[pg] = 1'b0;
        if (free_cnt < lim) free_cnt++;
        r.status = STAT_DONE;
      end
      r.free_now = free_cnt[12:0];
      return r;
    end
    need = (size == 0) ? 1 : (int'(size) + PAGE_BYTES - 1) / PAGE_BYTES;
    run_start = 0;
    run_len = 0;
    r.status = STAT_NORUN;
    for (int unsigned p = pg; p < lim; p++) begin
      if (page_used[p]) begin
        run_len = 0;
      end else begin
        if (run_len == 0) run_start = p;
        run_len++;
        if (run_len >= need) begin
          for (int unsigned q = run_start; q < run_start + run_len; q++) begin
            page_used[q] = 1'b1;
            if (free_cnt > 0) free_cnt--;
          end
          base = longint'(run_start) * PAGE_BYTES;
          r.status = STAT_DONE;
          r.addr = base[23:0];
          break;
        end
      end
    end
    r.free_now = free_cnt[12:0];
    return r;
  endfunction

  function automatic void report(string what, alloc_reply_t exp_r, alloc_reply_t got);
    n_fail++;
    if (n_fail <= 10)
      $display("%0t: %s: expected status %0d addr %h free %0d, got status %0d addr %h free %0d",
               $realtime, what, exp_r.status, exp_r.addr, exp_r.free_now,
               got.status, got.addr, got.free_now);
  endfunction

  initial begin
    n_fail = 0;
    n_pending = 0;
    reg_pages = NUM_PAGES;
    clear_map();
  end

  always @(posedge clk) begin
    alloc_reply_t got, exp_r;
    if (!rst_n) begin
      reg_pages = NUM_PAGES;
      clear_map();
      reply_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        reg_pages = 32'(cfg_total_pages);
        clear_map();
      end
      if (in_valid && in_ready)
        reply_q.push_back(compute_reply(in_cmd, in_addr, in_size_bytes));
      if (out_valid && out_ready) begin
        got = '{out_status, out_result_addr, out_free_pages_now};
        if (reply_q.size() == 0) begin
          report("unexpected result", '0, got);
        end else begin
          exp_r = reply_q.pop_front();
          if (got.status !== exp_r.status) report("status", exp_r, got);
          else if (got.addr !== exp_r.addr) report("result_addr", exp_r, got);
          else if (got.free_now !== exp_r.free_now) report("free_pages_now", exp_r, got);
        end
      end
    end
    n_pending <= reply_q.size();
  end

endmodule

[tb/bitmap_page_allocator_top_test.sv]
`timescale 1ns / 100ps
// stimulus and verdict for the bitmap page allocator
// depends on bitmap_page_allocator_top, bitmap_page_allocator_checker and bpa_pkg
module bitmap_page_allocator_top_test;
  import bpa_pkg::*;

  localparam int PAGE_BYTES = 4096;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid, in_ready, in_cmd;
  logic [23:0] in_addr;
  logic [24:0] in_size_bytes;
  logic        out_valid, out_ready;
  logic [1:0]  out_status;
  logic [23:0] out_result_addr;
  logic [12:0] out_free_pages_now;
  logic        cfg_valid, cfg_ready;
  logic [12:0] cfg_total_pages;
  int unsigned n_fail, n_pending;
  int unsigned idle_pct, stall_pct, cur_pages;

  always #6 clk = ~clk;

  bitmap_page_allocator_top DUT (.*);
  bitmap_page_allocator_checker u_checker (.*);

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  task automatic drain();
    do @(posedge clk); while (n_pending != 0);
  endtask

  task automatic send(logic cmd, logic [23:0] addr, logic [24:0] size);
    if (idle_pct != 0) begin
      while ($urandom_range(99) < idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_addr <= addr;
    in_size_bytes <= size;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_pages(logic [12:0] v);
    in_valid <= 1'b0;
    drain();
    cfg_valid <= 1'b1;
    cfg_total_pages <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_pages = (v > 4096) ? 4096 : v;
  endtask

  task automatic send_random();
    logic [23:0] a;
    logic [24:0] s;
    int unsigned r;
    a = 24'(($urandom_range(0, cur_pages + 1) * PAGE_BYTES) |
            $urandom_range(0, PAGE_BYTES - 1));
    if ($urandom_range(9) == 0) a = 24'($urandom);
    if ($urandom_range(99) < 55) begin
      r = $urandom_range(99);
      if (r < 10) s = '0;
      else if (r < 80)
        s = 25'($urandom_range(0, 4) * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1));
      else if (r < 95) s = 25'($urandom_range(0, 64 * PAGE_BYTES));
      else if (r < 97) s = 25'h1000000;
      else s = 25'($urandom);
      send(CMD_ALLOC, a, s);
    end else begin
      send(CMD_FREE, a, 25'($urandom));
    end
  endtask

  initial begin
    logic [12:0] pages_list [8];
    pages_list = '{13'd37, 13'd0, 13'd8191, 13'd1, 13'd300, 13'd4096, 13'd5000, 13'd12};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_ALLOC;
    in_addr = '0;
    in_size_bytes = '0;
    cfg_valid = 1'b0;
    cfg_total_pages = '0;
    out_ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    cur_pages = 4096;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset page count
    send(CMD_ALLOC, 24'h000000, 25'd0);
    send(CMD_ALLOC, 24'h000000, 25'd1);
    send(CMD_ALLOC, 24'h000fff, 25'd4096);
    send(CMD_ALLOC, 24'h000000, 25'd4097);
    send(CMD_ALLOC, 24'hffffff, 25'd1);
    send(CMD_ALLOC, 24'hfff000, 25'd8192);
    send(CMD_ALLOC, 24'h000000, 25'h1000000);
    send(CMD_ALLOC, 24'h000000, 25'h1ffffff);
    send(CMD_FREE, 24'h000abc, 25'h1ffffff);
    send(CMD_FREE, 24'h000abc, 25'd0);
    send(CMD_FREE, 24'hffffff, 25'd0);
    send(CMD_ALLOC, 24'h000000, 25'(4095 * 4096));
    send(CMD_ALLOC, 24'h000000, 25'd4096);
    // tiny memory: range errors, start beyond, double free at full count
    write_pages(13'd8);
    send(CMD_FREE, 24'h008000, 25'd0);
    send(CMD_FREE, 24'h007000, 25'd0);
    send(CMD_ALLOC, 24'h008000, 25'd1);
    send(CMD_ALLOC, 24'h000000, 25'(8 * 4096));
    send(CMD_ALLOC, 24'h000000, 25'd1);
    send(CMD_FREE, 24'h003000, 25'd0);
    send(CMD_FREE, 24'h003000, 25'd0);
    send(CMD_ALLOC, 24'h002000, 25'd4096);
    send(CMD_ALLOC, 24'h000000, 25'(2 * 4096));

    for (int ph = 0; ph < 8; ph++) begin
      write_pages(pages_list[ph]);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 79; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      for (int i = 0; i < 160; i++) begin
        // hold off once until the pipeline is empty
        if (ph == 2 && i == 80) begin
          in_valid <= 1'b0;
          drain();
        end
        send_random();
      end
    end
    in_valid <= 1'b0;
    drain();
    repeat (400) @(posedge clk);
    if (n_fail == 0 && n_pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #400_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[bitmap_page_allocator_top.f]
+incdir+sv
sv/bpa_pkg.sv
sv/bpa_scan.sv
sv/bitmap_page_allocator_top.sv
tb/bitmap_page_allocator_checker.sv
tb/bitmap_page_allocator_top_test.sv
